[rtl/conv3x3_same_pad_strided_unit_defines.svh]
// Assertion macros for the convolution unit's RTL files.
// Depends on nothing; included by name where assertions are written.
`ifndef CONV3X3_SAME_PAD_STRIDED_UNIT_DEFINES_SVH
`define CONV3X3_SAME_PAD_STRIDED_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CNV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CNV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cnv_pkg.sv]
// Package for the 3x3 strided convolution unit: constants, codes and helpers.
// Used by the top level and cnv_mac; depends on nothing.
package cnv_pkg;

    localparam int DEF_MAX_SIDE         = 64;
    localparam int DEF_MAX_IN_CHANNELS  = 32;
    localparam int DEF_MAX_OUT_CHANNELS = 64;
    localparam int DATA_BITS            = 16;
    localparam int FRAC_BITS            = 8;
    localparam int ADDR_BITS            = 17;
    localparam int COORD_BITS           = 6;
    localparam int SIDE_BITS            = 7;
    localparam int CIN_BITS             = 6;
    localparam int COUT_BITS            = 7;
    localparam int STRIDE_BITS          = 3;
    localparam int STRIDE_MAX           = 4;
    localparam int CFG_IDX_BITS         = 3;
    localparam int CFG_DATA_BITS        = 7;

    localparam logic [1:0] OP_ACT     = 2'd0;
    localparam logic [1:0] OP_WGT     = 2'd1;
    localparam logic [1:0] OP_BIAS    = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CIN    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE = 3'd4;

    typedef struct packed {
        logic load;
        logic valid;
    } t_mac_ctl;

    function automatic logic [31:0] cfg_clamp(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Ceiling of n / s for s in 1..4; division by three uses a reciprocal.
    function automatic logic [SIDE_BITS-1:0] ceil_div(input logic [SIDE_BITS-1:0] n,
                                                      input logic [STRIDE_BITS-1:0] s);
        logic [8:0]  t;
        logic [17:0] m;
        logic [SIDE_BITS-1:0] r;
        t = 9'(n) + 9'(s) - 9'd1;
        m = 18'(t) * 18'd171;
        case (s)
            3'd2: begin
                r = SIDE_BITS'(t >> 1);
            end
            3'd3: begin
                r = SIDE_BITS'(m >> 9);
            end
            3'd4: begin
                r = SIDE_BITS'(t >> 2);
            end
            default: begin
                r = n;
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/cnv_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module cnv_ram #(
    parameter int W = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/cnv_mac.sv]
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on cnv_pkg.
module cnv_mac #(
    parameter int ACC_W = 42
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cnv_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [ACC_W-1:0]              i_load_val,
    input  logic signed [cnv_pkg::DATA_BITS-1:0] i_a,
    input  logic signed [cnv_pkg::DATA_BITS-1:0] i_b,
    output logic signed [ACC_W-1:0]              o_acc,
    output logic                                 o_busy
);

    logic                                   r_pvalid;
    logic signed [2*cnv_pkg::DATA_BITS-1:0] r_prod;
    logic signed [ACC_W-1:0]                r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_ctl.valid;
        end
        r_prod <= i_a * i_b;
        if (i_ctl.load) begin
            r_acc <= i_load_val;
        end else if (r_pvalid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_pvalid;

endmodule

[rtl/conv3x3_same_pad_strided_unit.sv]
// Top level of the 3x3 strided SAME-padded convolution unit.
// Depends on cnv_pkg, cnv_ram, cnv_mac and the assertion macro header.
//
// Input items arrive on i_valid/o_stall. A write item (activation, weight,
// bias) is stored if its address fits its store and returns nothing. A
// compute item returns one output item on o_valid/i_stall with o_result
// and o_status. Its products run through the one shared multiply-accumulate
// unit, which handles one product per cycle. Taps outside the map are skipped
// without products, and a coordinate outside the output map goes straight
// from the range check to the result.
// o_stall is high while a compute item is in progress.
// The output item sits in a register until taken; a stalled receiver holds
// the next result back at the end of its computation only.
// Configuration writes use i_cfg_valid/o_cfg_ready and are always taken.
// Reset restores the register defaults and empties the output register;
// the stores keep undefined contents until written.
`include "conv3x3_same_pad_strided_unit_defines.svh"

module conv3x3_same_pad_strided_unit #(
    parameter int MAX_SIDE         = cnv_pkg::DEF_MAX_SIDE,
    parameter int MAX_IN_CHANNELS  = cnv_pkg::DEF_MAX_IN_CHANNELS,
    parameter int MAX_OUT_CHANNELS = cnv_pkg::DEF_MAX_OUT_CHANNELS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic [1:0]                               i_operation,
    input  logic [cnv_pkg::ADDR_BITS-1:0]            i_address,
    input  logic signed [cnv_pkg::DATA_BITS-1:0]     i_value,
    input  logic [cnv_pkg::COORD_BITS-1:0]           i_out_row,
    input  logic [cnv_pkg::COORD_BITS-1:0]           i_out_col,
    input  logic [cnv_pkg::COORD_BITS-1:0]           i_out_channel,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [cnv_pkg::DATA_BITS-1:0]     o_result,
    output logic [1:0]                               o_status,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [cnv_pkg::CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [cnv_pkg::CFG_DATA_BITS-1:0]        i_cfg_data
);

    localparam int DW         = cnv_pkg::DATA_BITS;
    localparam int ACT_DEPTH  = MAX_SIDE * MAX_SIDE * MAX_IN_CHANNELS;
    localparam int WGT_DEPTH  = 9 * MAX_IN_CHANNELS * MAX_OUT_CHANNELS;
    localparam int BIAS_DEPTH = MAX_OUT_CHANNELS;
    localparam int ACT_AW     = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
    localparam int PIX_AW     = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int ACC_W      = 2 * DW + $clog2(9 * MAX_IN_CHANNELS + 1) + 2;
    localparam int SW         = cnv_pkg::SIDE_BITS;
    localparam int CW         = cnv_pkg::CIN_BITS;
    localparam int OW         = cnv_pkg::COUT_BITS;
    localparam int TW         = cnv_pkg::STRIDE_BITS;
    localparam int YW         = 12;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RANGE = 3'd1;
    localparam logic [2:0] S_PAD   = 3'd2;
    localparam logic [2:0] S_TAP0  = 3'd3;
    localparam logic [2:0] S_TAP1  = 3'd4;
    localparam logic [2:0] S_RUN   = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (DW - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic [SW-1:0] r_height, r_width;
    logic [CW-1:0] r_cin;
    logic [OW-1:0] r_cout;
    logic [TW-1:0] r_stride;

    logic [2:0]                    r_state, n_state;
    logic [cnv_pkg::COORD_BITS-1:0] r_oy, r_ox, r_oc;
    logic [SW-1:0]                 r_oh, r_ow;
    logic signed [YW-1:0]          r_by, r_bx;
    logic [1:0]                    r_fy, r_fx;
    logic [PIX_AW-1:0]             r_pix;
    logic [9:0]                    r_tci;
    logic [ACT_AW-1:0]             r_abase;
    logic [WGT_AW-1:0]             r_waddr;
    logic [CW-1:0]                 r_ic;
    logic                          r_v1;
    logic                          r_oor;
    logic                          r_ovalid;
    logic signed [DW-1:0]          r_result;
    logic [1:0]                    r_status;

    logic                  in_accept;
    logic [ACT_AW-1:0]     act_raddr;
    logic [DW-1:0]         act_rdata, wgt_rdata, bias_rdata;
    logic                  act_we, wgt_we, bias_we;
    logic [SW-1:0]         oh_c, ow_c;
    logic                  oor_c;
    logic signed [YW-1:0]  pad_h, pad_w, pad_top, pad_start_x;
    logic signed [YW-1:0]  iy, ix;
    logic                  tap_ok, tap_last, ic_last, out_free;
    logic [3:0]            tap_idx;
    logic signed [ACC_W-1:0] acc, acc_sh, bias_ext;
    logic                  mac_busy;
    cnv_pkg::t_mac_ctl     mac_ctl;

    assign in_accept   = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_result    = r_result;
    assign o_status    = r_status;
    assign out_free    = !r_ovalid || !i_stall;

    assign act_we  = in_accept && (i_operation == cnv_pkg::OP_ACT)
                     && (32'(i_address) < 32'(ACT_DEPTH));
    assign wgt_we  = in_accept && (i_operation == cnv_pkg::OP_WGT)
                     && (32'(i_address) < 32'(WGT_DEPTH));
    assign bias_we = in_accept && (i_operation == cnv_pkg::OP_BIAS)
                     && (32'(i_address) < 32'(BIAS_DEPTH));

    cnv_ram #(.W(DW), .DEPTH(ACT_DEPTH)) u_act (
        .i_clk(i_clk), .i_we(act_we), .i_waddr(ACT_AW'(i_address)),
        .i_wdata(i_value), .i_raddr(act_raddr), .o_rdata(act_rdata)
    );
    cnv_ram #(.W(DW), .DEPTH(WGT_DEPTH)) u_wgt (
        .i_clk(i_clk), .i_we(wgt_we), .i_waddr(WGT_AW'(i_address)),
        .i_wdata(i_value), .i_raddr(r_waddr), .o_rdata(wgt_rdata)
    );
    cnv_ram #(.W(DW), .DEPTH(BIAS_DEPTH)) u_bias (
        .i_clk(i_clk), .i_we(bias_we), .i_waddr(BIAS_AW'(i_address)),
        .i_wdata(i_value), .i_raddr(BIAS_AW'(r_oc)), .o_rdata(bias_rdata)
    );

    assign bias_ext      = ACC_W'($signed(bias_rdata));
    assign mac_ctl.load  = (r_state == S_PAD);
    assign mac_ctl.valid = r_v1;

    cnv_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(mac_ctl),
        .i_load_val(bias_ext <<< cnv_pkg::FRAC_BITS),
        .i_a($signed(act_rdata)), .i_b($signed(wgt_rdata)),
        .o_acc(acc), .o_busy(mac_busy)
    );

    assign act_raddr = ACT_AW'(r_abase + ACT_AW'(r_ic));

    always_comb begin
        oh_c     = cnv_pkg::ceil_div(r_height, r_stride);
        ow_c     = cnv_pkg::ceil_div(r_width, r_stride);
        oor_c    = (SW'(r_oy) >= oh_c) || (SW'(r_ox) >= ow_c) || (OW'(r_oc) >= r_cout);
        pad_h    = $signed(YW'(10'(r_oh - SW'(1)) * 10'(r_stride))) + YW'(3)
                   - $signed(YW'(r_height));
        pad_w    = $signed(YW'(10'(r_ow - SW'(1)) * 10'(r_stride))) + YW'(3)
                   - $signed(YW'(r_width));
        pad_top  = pad_h[YW-1] ? '0 : (pad_h >>> 1);
        pad_start_x = pad_w[YW-1] ? '0 : (pad_w >>> 1);
        iy       = r_by + $signed(YW'(r_fy));
        ix       = r_bx + $signed(YW'(r_fx));
        tap_ok   = !iy[YW-1] && !ix[YW-1] && (iy < $signed(YW'(r_height)))
                   && (ix < $signed(YW'(r_width)));
        tap_last = (r_fy == 2'd2) && (r_fx == 2'd2);
        tap_idx  = 4'(r_fy) * 4'd3 + 4'(r_fx);
        ic_last  = (r_ic == r_cin - CW'(1));
        acc_sh   = acc >>> cnv_pkg::FRAC_BITS;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_operation == cnv_pkg::OP_COMPUTE)) begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                n_state = oor_c ? S_DONE : S_PAD;
            end
            S_PAD: begin
                n_state = S_TAP0;
            end
            S_TAP0: begin
                if (tap_ok) begin
                    n_state = S_TAP1;
                end else if (tap_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_TAP1: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (ic_last) begin
                    n_state = tap_last ? S_DRAIN : S_TAP0;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !mac_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v1     <= 1'b0;
            r_ovalid <= 1'b0;
            r_height <= SW'(cnv_pkg::cfg_clamp(32'd64, 32'(MAX_SIDE)));
            r_width  <= SW'(cnv_pkg::cfg_clamp(32'd64, 32'(MAX_SIDE)));
            r_cin    <= CW'(cnv_pkg::cfg_clamp(32'd3, 32'(MAX_IN_CHANNELS)));
            r_cout   <= OW'(cnv_pkg::cfg_clamp(32'd32, 32'(MAX_OUT_CHANNELS)));
            r_stride <= TW'(2);
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_RUN);
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cnv_pkg::REG_HEIGHT: begin
                        r_height <= SW'(cnv_pkg::cfg_clamp(32'(i_cfg_data), 32'(MAX_SIDE)));
                    end
                    cnv_pkg::REG_WIDTH: begin
                        r_width <= SW'(cnv_pkg::cfg_clamp(32'(i_cfg_data), 32'(MAX_SIDE)));
                    end
                    cnv_pkg::REG_CIN: begin
                        r_cin <= CW'(cnv_pkg::cfg_clamp(32'(i_cfg_data[CW-1:0]),
                                                        32'(MAX_IN_CHANNELS)));
                    end
                    cnv_pkg::REG_COUT: begin
                        r_cout <= OW'(cnv_pkg::cfg_clamp(32'(i_cfg_data),
                                                         32'(MAX_OUT_CHANNELS)));
                    end
                    cnv_pkg::REG_STRIDE: begin
                        r_stride <= TW'(cnv_pkg::cfg_clamp(32'(i_cfg_data[TW-1:0]),
                                                           32'(cnv_pkg::STRIDE_MAX)));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_oy <= i_out_row;
                r_ox <= i_out_col;
                r_oc <= i_out_channel;
            end
            S_RANGE: begin
                r_oh  <= oh_c;
                r_ow  <= ow_c;
                r_oor <= oor_c;
            end
            S_PAD: begin
                r_by <= $signed(YW'(9'(r_oy) * 9'(r_stride))) - pad_top;
                r_bx <= $signed(YW'(9'(r_ox) * 9'(r_stride))) - pad_start_x;
                r_fy <= 2'd0;
                r_fx <= 2'd0;
            end
            S_TAP0: begin
                r_pix <= PIX_AW'(15'(iy[SW-1:0]) * 15'(r_width) + 15'(ix[SW-1:0]));
                r_tci <= 10'(tap_idx) * 10'(r_cin);
                if (!tap_ok) begin
                    r_fx <= (r_fx == 2'd2) ? 2'd0 : r_fx + 2'd1;
                    r_fy <= (r_fx == 2'd2) ? r_fy + 2'd1 : r_fy;
                end
            end
            S_TAP1: begin
                r_abase <= ACT_AW'(32'(r_pix) * 32'(r_cin));
                r_waddr <= WGT_AW'(32'(r_tci) * 32'(r_cout) + 32'(r_oc));
                r_ic    <= '0;
            end
            S_RUN: begin
                r_waddr <= WGT_AW'(32'(r_waddr) + 32'(r_cout));
                r_ic    <= r_ic + CW'(1);
                if (ic_last) begin
                    r_fx <= (r_fx == 2'd2) ? 2'd0 : r_fx + 2'd1;
                    r_fy <= (r_fx == 2'd2) ? r_fy + 2'd1 : r_fy;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    if (r_oor) begin
                        r_result <= '0;
                        r_status <= cnv_pkg::ST_RANGE;
                    end else if (acc_sh > SAT_HI) begin
                        r_result <= DW'(SAT_HI);
                        r_status <= cnv_pkg::ST_SAT;
                    end else if (acc_sh < SAT_LO) begin
                        r_result <= DW'(SAT_LO);
                        r_status <= cnv_pkg::ST_SAT;
                    end else begin
                        r_result <= DW'(acc_sh);
                        r_status <= cnv_pkg::ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    `CNV_ASSERT_NEXT(a_compute_starts, i_clk, i_rst_n, in_accept && (i_operation == cnv_pkg::OP_COMPUTE), r_state == S_RANGE, "compute item did not start")
    `CNV_ASSERT_NOW(a_done_drained, i_clk, i_rst_n, r_state == S_DONE, !mac_busy && !r_v1, "result taken before accumulation finished")
    `CNV_ASSERT_NEXT(a_out_from_done, i_clk, i_rst_n, (r_state != S_DONE) && !r_ovalid, !r_ovalid, "output item appeared without a finished computation")
    `CNV_ASSERT_NOW(a_ic_in_range, i_clk, i_rst_n, r_state == S_RUN, r_ic < r_cin, "input channel counter past in_channels")

endmodule

[sim/tb_conv3x3_same_pad_strided_unit.sv]
// Self-checking testbench for the 3x3 strided SAME-padded convolution unit.
// A queue-fed driver and a checking monitor run against a built-in predictor.
// Depends on cnv_pkg and the conv3x3_same_pad_strided_unit RTL.
`timescale 1ns / 100ps

module tb_conv3x3_same_pad_strided_unit;

    localparam int ACT_WORDS   = cnv_pkg::DEF_MAX_SIDE * cnv_pkg::DEF_MAX_SIDE
                                 * cnv_pkg::DEF_MAX_IN_CHANNELS;
    localparam int WGT_WORDS   = 9 * cnv_pkg::DEF_MAX_IN_CHANNELS * cnv_pkg::DEF_MAX_OUT_CHANNELS;
    localparam int BIAS_WORDS  = cnv_pkg::DEF_MAX_OUT_CHANNELS;
    localparam logic [cnv_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 600;
    localparam int WD_LIMIT    = 5000;

    typedef struct {
        logic [1:0]                           op;
        logic [cnv_pkg::ADDR_BITS-1:0]        addr;
        logic signed [cnv_pkg::DATA_BITS-1:0] value;
        logic [cnv_pkg::COORD_BITS-1:0]       row;
        logic [cnv_pkg::COORD_BITS-1:0]       col;
        logic [cnv_pkg::COORD_BITS-1:0]       chan;
    } t_conv_item;

    typedef struct {
        logic signed [cnv_pkg::DATA_BITS-1:0] result;
        logic [1:0]                           status;
    } t_conv_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_operation = cnv_pkg::OP_ACT;
    logic [cnv_pkg::ADDR_BITS-1:0] i_address = '0;
    logic signed [cnv_pkg::DATA_BITS-1:0] i_value = '0;
    logic [cnv_pkg::COORD_BITS-1:0] i_out_row = '0;
    logic [cnv_pkg::COORD_BITS-1:0] i_out_col = '0;
    logic [cnv_pkg::COORD_BITS-1:0] i_out_channel = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [cnv_pkg::DATA_BITS-1:0] o_result;
    logic [1:0] o_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [cnv_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [cnv_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;

    conv3x3_same_pad_strided_unit DUT (.*);

    logic signed [cnv_pkg::DATA_BITS-1:0] act_mem [ACT_WORDS];
    logic signed [cnv_pkg::DATA_BITS-1:0] wgt_mem [WGT_WORDS];
    logic signed [cnv_pkg::DATA_BITS-1:0] bias_mem [BIAS_WORDS];
    int map_h = 64, map_w = 64, n_cin = 3, n_cout = 32, step = 2;

    t_conv_item pending_q[$];
    t_conv_out  conv_expect_q[$];
    t_conv_item cur_item;
    int in_gap = 0, out_gap = 0, hold_left = 0;
    int hold_req = 0, hold_seen = 0;
    bit idle_on = 1'b1;
    int mismatches = 0;
    int wd_count = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int clamp_reg(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void predict_conv(t_conv_item it);
        t_conv_out e;
        int oh, ow, pad_t, pad_l, iy, ix;
        longint acc, sh;
        case (it.op)
            cnv_pkg::OP_ACT: act_mem[it.addr] = it.value;
            cnv_pkg::OP_WGT: if (it.addr < WGT_WORDS) wgt_mem[it.addr] = it.value;
            cnv_pkg::OP_BIAS: if (it.addr < BIAS_WORDS) bias_mem[it.addr] = it.value;
            default: begin
                oh = (map_h + step - 1) / step;
                ow = (map_w + step - 1) / step;
                if (it.row >= oh || it.col >= ow || it.chan >= n_cout) begin
                    e.result = '0;
                    e.status = cnv_pkg::ST_RANGE;
                end else begin
                    pad_t = ((oh - 1) * step + 3 - map_h);
                    pad_l = ((ow - 1) * step + 3 - map_w);
                    pad_t = (pad_t < 0) ? 0 : pad_t / 2;
                    pad_l = (pad_l < 0) ? 0 : pad_l / 2;
                    acc = longint'(bias_mem[it.chan]) * 256;
                    for (int fy = 0; fy < 3; fy++) begin
                        iy = it.row * step - pad_t + fy;
                        if (iy < 0 || iy >= map_h) continue;
                        for (int fx = 0; fx < 3; fx++) begin
                            ix = it.col * step - pad_l + fx;
                            if (ix < 0 || ix >= map_w) continue;
                            for (int ic = 0; ic < n_cin; ic++) begin
                                acc += longint'(act_mem[(iy * map_w + ix) * n_cin + ic])
                                    * longint'(wgt_mem[((fy * 3 + fx) * n_cin + ic)
                                    * n_cout + it.chan]);
                            end
                        end
                    end
                    sh = acc >>> 8;
                    e.status = cnv_pkg::ST_OK;
                    if (sh > 32767) begin
                        e.result = 16'sh7fff;
                        e.status = cnv_pkg::ST_SAT;
                    end else if (sh < -32768) begin
                        e.result = 16'sh8000;
                        e.status = cnv_pkg::ST_SAT;
                    end else begin
                        e.result = cnv_pkg::DATA_BITS'(sh);
                    end
                end
                conv_expect_q.push_back(e);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_conv(cur_item);
            end
            if (i_valid && o_stall) begin
                i_valid <= 1'b1;
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_item = pending_q.pop_front();
                i_operation <= cur_item.op;
                i_address <= cur_item.addr;
                i_value <= cur_item.value;
                i_out_row <= cur_item.row;
                i_out_col <= cur_item.col;
                i_out_channel <= cur_item.chan;
                i_valid <= 1'b1;
                in_gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_conv_out e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (conv_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected output item: result %0d status %0d",
                                 o_result, o_status);
                end else begin
                    e = conv_expect_q.pop_front();
                    if (o_result !== e.result || o_status !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %0d/%0d, got %0d/%0d",
                                     e.result, e.status, o_result, o_status);
                    end
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                i_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_stall <= 1'b1;
            end else begin
                out_gap <= pick_gap();
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            wd_count <= 0;
        end else if (wd_count >= WD_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            wd_count <= wd_count + 1;
        end
    end

    task automatic push_item(logic [1:0] op, int addr, int value, int row, int col, int chan);
        t_conv_item it;
        it.op = op;
        it.addr = cnv_pkg::ADDR_BITS'(addr);
        it.value = cnv_pkg::DATA_BITS'(value);
        it.row = cnv_pkg::COORD_BITS'(row);
        it.col = cnv_pkg::COORD_BITS'(col);
        it.chan = cnv_pkg::COORD_BITS'(chan);
        pending_q.push_back(it);
    endtask

    function automatic int rand_value();
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 65535) - 32768;
        return $urandom_range(0, 1023) - 512;
    endfunction

    task automatic set_config(int h, int w, int cin, int cout, int s);
        logic [cnv_pkg::CFG_IDX_BITS-1:0] idx [6];
        int data [6];
        idx = '{cnv_pkg::REG_HEIGHT, cnv_pkg::REG_WIDTH, cnv_pkg::REG_CIN,
                cnv_pkg::REG_COUT, cnv_pkg::REG_STRIDE, REG_UNUSED};
        data = '{h, w, cin, cout, s, $urandom_range(0, 127)};
        for (int k = 0; k < 6; k++) begin
            @(posedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= cnv_pkg::CFG_DATA_BITS'(data[k]);
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                cnv_pkg::REG_HEIGHT: map_h = clamp_reg(data[k] & 'h7f, cnv_pkg::DEF_MAX_SIDE);
                cnv_pkg::REG_WIDTH: map_w = clamp_reg(data[k] & 'h7f, cnv_pkg::DEF_MAX_SIDE);
                cnv_pkg::REG_CIN: n_cin = clamp_reg(data[k] & 'h3f,
                                                    cnv_pkg::DEF_MAX_IN_CHANNELS);
                cnv_pkg::REG_COUT: n_cout = clamp_reg(data[k] & 'h7f,
                                                      cnv_pkg::DEF_MAX_OUT_CHANNELS);
                cnv_pkg::REG_STRIDE: step = clamp_reg(data[k] & 'h7, cnv_pkg::STRIDE_MAX);
                default: ;
            endcase
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic fill_stores();
        for (int a = 0; a < map_h * map_w * n_cin; a++)
            push_item(cnv_pkg::OP_ACT, a, rand_value(), 0, 0, 0);
        for (int a = 0; a < 9 * n_cin * n_cout; a++)
            push_item(cnv_pkg::OP_WGT, a, rand_value(), 0, 0, 0);
        for (int a = 0; a < n_cout; a++)
            push_item(cnv_pkg::OP_BIAS, a, rand_value(), 0, 0, 0);
    endtask

    task automatic random_computes(int count);
        int oh, ow, r;
        oh = (map_h + step - 1) / step;
        ow = (map_w + step - 1) / step;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_item(cnv_pkg::OP_COMPUTE, $urandom_range(0, 131071), rand_value(),
                          $urandom_range(0, oh - 1), $urandom_range(0, ow - 1),
                          $urandom_range(0, n_cout - 1));
            end else if (r < 80) begin
                push_item(cnv_pkg::OP_COMPUTE, $urandom_range(0, 131071), rand_value(),
                          $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
            end else if (r < 88) begin
                push_item(cnv_pkg::OP_WGT, $urandom_range(0, 9 * n_cin * n_cout - 1),
                          rand_value(), $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 63));
            end else if (r < 92) begin
                push_item(cnv_pkg::OP_BIAS, $urandom_range(0, n_cout - 1), rand_value(),
                          0, 0, 0);
            end else if (r < 96) begin
                push_item(cnv_pkg::OP_ACT, $urandom_range(0, 131071), rand_value(), 0, 0, 0);
            end else begin
                push_item($urandom_range(0, 1) ? cnv_pkg::OP_WGT : cnv_pkg::OP_BIAS,
                          $urandom_range(WGT_WORDS, 131071), rand_value(), 0, 0, 0);
            end
        end
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !i_valid && conv_expect_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(5, 7, 2, 3, 1);
        fill_stores();
        push_item(cnv_pkg::OP_WGT, WGT_WORDS, 16'sh7fff, 0, 0, 0);
        push_item(cnv_pkg::OP_BIAS, BIAS_WORDS, 16'sh7fff, 0, 0, 0);
        push_item(cnv_pkg::OP_BIAS, 131071, -1, 0, 0, 0);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 0, 0, 0);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 4, 6, 2);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 63, 0, 0);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 0, 63, 0);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 0, 0, 63);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 5, 0, 0);
        push_item(cnv_pkg::OP_BIAS, 1, 32767, 0, 0, 0);
        push_item(cnv_pkg::OP_BIAS, 2, -32768, 0, 0, 0);
        push_item(cnv_pkg::OP_ACT, 0, 32767, 0, 0, 0);
        push_item(cnv_pkg::OP_ACT, 1, -32768, 0, 0, 0);
        push_item(cnv_pkg::OP_WGT, 1, 32767, 0, 0, 0);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 0, 0, 1);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 0, 0, 2);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 2, 3, 1);
        drain();

        set_config(0, 0, 0, 0, 0);
        fill_stores();
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 0, 0, 0);
        push_item(cnv_pkg::OP_COMPUTE, 0, 0, 1, 0, 0);
        random_computes(10);
        drain();

        set_config(6, 5, 1, 2, 7);
        fill_stores();
        random_computes(40);
        hold_req++;
        drain();

        set_config(3, 2, 3, 2, 3);
        fill_stores();
        random_computes(20);
        drain();

        for (int p = 0; p < 2; p++) begin
            idle_on = (p != 0);
            set_config($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 2),
                       $urandom_range(1, 2), $urandom_range(1, 4));
            fill_stores();
            random_computes(20);
            drain();
        end
        idle_on = 1'b1;

        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && conv_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
